### rtl/rmth_pkg.sv
// Package for the running median (two heaps) core.
// Holds default sizes, fixed result widths and the sequencer state type.
// Used by running_median_two_heaps_core.
package rmth_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_SAMPLE_W = 32;
    localparam int SUM_W        = 42;
    localparam int COUNT_W      = 10;

    // Which heap the sequencer works on
    typedef enum logic {
        HEAP_LOWER = 1'b0,   // max-heap
        HEAP_UPPER = 1'b1    // min-heap
    } t_heap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PUSH_CMP,
        S_BAL,
        S_POP_LAST,
        S_POP_C,
        S_POP_C1,
        S_POP_C2,
        S_POP_CMP,
        S_POP_FIN,
        S_DONE
    } t_state;

endpackage

### rtl/rmth_ram.sv
// Single-port synchronous RAM, one heap store.
// Registered read data, read-before-write.
// No dependencies.
module rmth_ram #(
    parameter int DEPTH = 513,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/running_median_two_heaps_core.sv
// Running median core: lower max-heap and upper min-heap in two RAMs.
// Depends on rmth_pkg and rmth_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  sample  | in        | i_valid / o_stall   | i_sample
//  result  | out       | o_valid / i_stall   | o_median, o_lower_sum, o_upper_sum,
//          |           |                     | o_lower_count, o_upper_count, o_dropped
//
// One request at a time. A push walks up its heap and a pop walks down it, level
// by level, since every heap access goes through one single-port RAM access a
// cycle; an insert may be followed by a rebalance that moves one heap's top into
// the other, and a dropped request skips both. Reset (synchronous) empties both heaps
// at once by clearing the sizes; RAM contents are never cleared. A stalled result
// holds in the output register while the next request is already being worked on.
module running_median_two_heaps_core #(
    parameter int CAPACITY     = rmth_pkg::DEF_CAPACITY,
    parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_median,
    output logic signed [rmth_pkg::SUM_W-1:0]   o_lower_sum,
    output logic signed [rmth_pkg::SUM_W-1:0]   o_upper_sum,
    output logic [rmth_pkg::COUNT_W-1:0]        o_lower_count,
    output logic [rmth_pkg::COUNT_W-1:0]        o_upper_count,
    output logic                                o_dropped
);

    import rmth_pkg::*;

    localparam int DEPTH = CAPACITY / 2 + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // heap index
    localparam int SW    = $clog2(DEPTH + 1);                 // heap size
    localparam int CW    = IW + 2;                            // child index compare
    localparam int TW    = $clog2(CAPACITY + 1) + 1;          // total fill

    typedef logic signed [SAMPLE_WIDTH-1:0] t_val;

    t_state r_state, n_state;
    t_heap  r_sel, c_heap;
    logic   r_after;              // first push of a request: rebalance follows

    logic [SW-1:0] r_lsize, r_usize, r_n;
    logic [SUM_W-1:0] r_lsum, r_usum;
    t_val  r_ltop, r_utop, r_val, r_cand, r_t;
    logic [IW-1:0] r_idx, r_cidx;
    logic  r_drop;

    logic  r_out_valid, r_out_drop;
    t_val  r_out_med;
    logic [SUM_W-1:0] r_out_lsum, r_out_usum;
    logic [COUNT_W-1:0] r_out_lcnt, r_out_ucnt;

    // memory controls
    logic          c_we;
    logic [IW-1:0] c_addr;
    t_val          c_wdata;
    t_val          lo_rd, up_rd, rdata;

    // derived values
    logic          fill_full, go_upper, move_up, move_down;
    logic [CW-1:0] c_child, c_child1, c_n;
    logic          child_out, child1_in;
    logic          above_push, above_c2, above_cmp;
    logic [IW-1:0] parent;
    logic          out_free;
    logic [SW-1:0] src_size;

    assign rdata = (r_sel == HEAP_UPPER) ? up_rd : lo_rd;

    assign fill_full = (TW'(r_lsize) + TW'(r_usize)) >= TW'(CAPACITY);
    assign go_upper  = (r_lsize != '0) && (r_ltop < i_sample);
    assign move_up   = (r_lsize == r_usize + SW'(2));
    assign move_down = (r_usize == r_lsize + SW'(1));
    assign src_size  = move_down ? r_usize : r_lsize;

    assign parent    = IW'((r_idx - IW'(1)) >> 1);
    assign c_child   = {1'b0, r_idx, 1'b1};
    assign c_child1  = c_child + CW'(1);
    assign c_n       = CW'(r_n);
    assign child_out = c_child >= c_n;
    assign child1_in = c_child1 < c_n;

    // "belongs above" for the heap in work: greater for max-heap, smaller for min-heap
    assign above_push = (r_sel == HEAP_LOWER) ? (r_val > rdata)  : (r_val < rdata);
    assign above_c2   = (r_sel == HEAP_LOWER) ? (rdata > r_cand) : (rdata < r_cand);
    assign above_cmp  = (r_sel == HEAP_LOWER) ? (r_cand > r_val) : (r_cand < r_val);

    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = fill_full ? S_DONE : S_PUSH;
                end
            end
            S_PUSH: begin
                if (r_idx == '0) begin
                    n_state = r_after ? S_BAL : S_DONE;
                end else begin
                    n_state = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                if (above_push) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = r_after ? S_BAL : S_DONE;
                end
            end
            S_BAL: begin
                if (move_up || move_down) begin
                    n_state = (src_size == SW'(1)) ? S_POP_FIN : S_POP_LAST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_LAST: n_state = S_POP_C;
            S_POP_C:    n_state = child_out ? S_POP_FIN : S_POP_C1;
            S_POP_C1:   n_state = child1_in ? S_POP_C2 : S_POP_CMP;
            S_POP_C2:   n_state = S_POP_CMP;
            S_POP_CMP:  n_state = above_cmp ? S_POP_C : S_POP_FIN;
            S_POP_FIN:  n_state = S_PUSH;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory access per state
    always_comb begin
        c_we    = 1'b0;
        c_addr  = r_idx;
        c_wdata = r_val;
        c_heap  = r_sel;
        case (r_state)
            S_PUSH: begin
                if (r_idx == '0) begin
                    c_we = 1'b1;
                end else begin
                    c_addr = parent;
                end
            end
            S_PUSH_CMP: begin
                c_we    = 1'b1;
                c_wdata = above_push ? rdata : r_val;
            end
            S_BAL: begin
                c_heap = move_down ? HEAP_UPPER : HEAP_LOWER;
                c_addr = IW'(src_size - SW'(1));
            end
            S_POP_C: begin
                if (child_out) begin
                    c_we = 1'b1;
                end else begin
                    c_addr = IW'(c_child);
                end
            end
            S_POP_C1: begin
                c_addr = IW'(c_child1);
            end
            S_POP_CMP: begin
                c_we    = 1'b1;
                c_wdata = above_cmp ? r_cand : r_val;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    rmth_ram #(.DEPTH(DEPTH), .WIDTH(SAMPLE_WIDTH), .AW(IW)) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (c_we && (c_heap == HEAP_LOWER)),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (lo_rd)
    );

    rmth_ram #(.DEPTH(DEPTH), .WIDTH(SAMPLE_WIDTH), .AW(IW)) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (c_we && (c_heap == HEAP_UPPER)),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (up_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lsize     <= '0;
            r_usize     <= '0;
            r_lsum      <= '0;
            r_usum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !fill_full) begin
                        if (go_upper) begin
                            r_usize <= r_usize + SW'(1);
                            r_usum  <= r_usum + SUM_W'(i_sample);
                        end else begin
                            r_lsize <= r_lsize + SW'(1);
                            r_lsum  <= r_lsum + SUM_W'(i_sample);
                        end
                    end
                end
                S_BAL: begin
                    if (move_down) begin
                        r_usize <= r_usize - SW'(1);
                        r_usum  <= r_usum - SUM_W'(r_utop);
                    end else if (move_up) begin
                        r_lsize <= r_lsize - SW'(1);
                        r_lsum  <= r_lsum - SUM_W'(r_ltop);
                    end
                end
                S_POP_FIN: begin
                    // popped top goes into the other heap
                    if (r_sel == HEAP_LOWER) begin
                        r_usize <= r_usize + SW'(1);
                        r_usum  <= r_usum + SUM_W'(r_t);
                    end else begin
                        r_lsize <= r_lsize + SW'(1);
                        r_lsum  <= r_lsum + SUM_W'(r_t);
                    end
                end
                default: begin
                    r_lsize <= r_lsize;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // cached heap tops follow every write of entry zero
        if (c_we && c_addr == '0) begin
            if (c_heap == HEAP_LOWER) begin
                r_ltop <= c_wdata;
            end else begin
                r_utop <= c_wdata;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_drop  <= fill_full;
                r_after <= 1'b1;
                r_val   <= i_sample;
                if (go_upper) begin
                    r_sel <= HEAP_UPPER;
                    r_idx <= IW'(r_usize);
                end else begin
                    r_sel <= HEAP_LOWER;
                    r_idx <= IW'(r_lsize);
                end
            end
            S_PUSH_CMP: begin
                if (above_push) begin
                    r_idx <= parent;
                end
            end
            S_BAL: begin
                r_sel <= move_down ? HEAP_UPPER : HEAP_LOWER;
                r_t   <= move_down ? r_utop : r_ltop;
                r_n   <= src_size - SW'(1);
                r_idx <= '0;
            end
            S_POP_LAST: begin
                r_val <= rdata;
            end
            S_POP_C1: begin
                r_cand <= rdata;
                r_cidx <= IW'(c_child);
            end
            S_POP_C2: begin
                if (above_c2) begin
                    r_cand <= rdata;
                    r_cidx <= IW'(c_child1);
                end
            end
            S_POP_CMP: begin
                if (above_cmp) begin
                    r_idx <= r_cidx;
                end
            end
            S_POP_FIN: begin
                r_after <= 1'b0;
                r_val   <= r_t;
                if (r_sel == HEAP_LOWER) begin
                    r_sel <= HEAP_UPPER;
                    r_idx <= IW'(r_usize);
                end else begin
                    r_sel <= HEAP_LOWER;
                    r_idx <= IW'(r_lsize);
                end
            end
            default: begin
                r_after <= r_after;
            end
        endcase
        // result register
        if (r_state == S_DONE && out_free) begin
            r_out_med  <= (r_lsize != '0) ? r_ltop : '0;
            r_out_lsum <= r_lsum;
            r_out_usum <= r_usum;
            r_out_lcnt <= COUNT_W'(r_lsize);
            r_out_ucnt <= COUNT_W'(r_usize);
            r_out_drop <= r_drop;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_median      = r_out_med;
    assign o_lower_sum   = r_out_lsum;
    assign o_upper_sum   = r_out_usum;
    assign o_lower_count = r_out_lcnt;
    assign o_upper_count = r_out_ucnt;
    assign o_dropped     = r_out_drop;

`ifndef ASSERT_OFF
    // balance holds between requests
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lsize == r_usize || r_lsize == r_usize + SW'(1)))
        else $error("heap sizes out of balance");

    // fill never exceeds capacity
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TW'(r_lsize) + TW'(r_usize)) <= TW'(CAPACITY))
        else $error("store overfilled");

    // a result appears only out of the finishing state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result without finished request");

    // a drop is reported only when the store is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> fill_full)
        else $error("drop reported while store not full");
`endif

endmodule
